// ===== rtl/dec_calc_pkg.sv =====
// Shared codes and character constants for the decimal expression calculator.
`timescale 1ns / 1ps

package dec_calc_pkg;

  // Line parse phase; the unused code behaves like PH_IGNORE.
  typedef enum logic [1:0] {
    PH_FIRST  = 2'd0,
    PH_SECOND = 2'd1,
    PH_IGNORE = 2'd2
  } phase_t;

  typedef enum logic [2:0] {
    OP_NONE = 3'd0,
    OP_ADD  = 3'd1,
    OP_SUB  = 3'd2,
    OP_MUL  = 3'd3,
    OP_DIV  = 3'd4
  } op_t;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_BAD  = 2'd1;
  localparam logic [1:0] ST_DIVZ = 2'd2;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned CNT_W  = $clog2(WORD_W);

endpackage

// ===== rtl/decimal_expression_calculator.sv =====
// Top level of the decimal expression calculator: parser, shared ALU and sequencer.
`timescale 1ns / 1ps

// Usage:
//   in_*  : one ASCII character per request on in_tdata. NUL ends the line.
//   out_* : one result per line; out_tdata is the signed 32-bit value,
//           out_tuser the status (0 ok, 1 bad input, 2 divide by zero).
//   Any character other than NUL is taken while the block is idle and gives no result.
//   On NUL the block drops in_tready and evaluates with one shared 33-bit
//   adder/subtractor driven by a small sequencer:
//     no operator or zero divisor : straight to the done state and the output register
//     add or subtract             : one pass through the shared adder
//     multiply (shift-add)        : one multiplier bit per cycle
//     divide (restoring)          : sign fix-up around 32 steps
//   The iteration count of the shared adder sets the line-end latency; the
//   sustained rate is one character per cycle between terminators.
//   The result waits in an output register; characters of the next line are
//   still taken while it waits. If a new line ends before the old result is
//   taken, the sequencer holds its result in the done state until the slot
//   frees. Reset (rst_n low, synchronous) empties the output and returns
//   the parser to the first number phase with zero operands.
module decimal_expression_calculator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] ch
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] value (signed)
  output logic [1:0]  out_tuser   // [1:0] status
);

  localparam int unsigned W  = dec_calc_pkg::WORD_W;
  localparam int unsigned CW = dec_calc_pkg::CNT_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ADDSUB,
    S_MUL,
    S_NEGA,
    S_NEGB,
    S_DIV,
    S_FIX,
    S_DONE
  } state_t;

  state_t               state_r;
  dec_calc_pkg::phase_t phase_r;
  dec_calc_pkg::op_t    op_r;
  logic [W-1:0]         a_r;       // first operand, then multiplicand / dividend-quotient
  logic [W-1:0]         b_r;       // second operand, then multiplier / divisor
  logic [W-1:0]         acc_r;     // product, remainder, then result
  logic [1:0]           st_r;
  logic                 neg_r;
  logic [CW-1:0]        cnt_r;
  logic                 out_tvalid_r;
  logic [W-1:0]         out_value_r;
  logic [1:0]           out_status_r;

  // Request handshakes
  logic in_acc;
  logic out_free;
  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_tvalid_r || out_tready;

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_value_r;
  assign out_tuser  = out_status_r;

  // Character decode
  logic                 is_digit;
  logic [3:0]           digit;
  logic [7:0]           ch_off;
  dec_calc_pkg::op_t    ch_op;
  assign is_digit = (in_tdata >= dec_calc_pkg::CH_ZERO) && (in_tdata <= dec_calc_pkg::CH_NINE);
  assign ch_off   = in_tdata - dec_calc_pkg::CH_ZERO;
  assign digit    = ch_off[3:0];

  always_comb begin
    priority if (in_tdata == dec_calc_pkg::CH_PLUS)  ch_op = dec_calc_pkg::OP_ADD;
    else if     (in_tdata == dec_calc_pkg::CH_MINUS) ch_op = dec_calc_pkg::OP_SUB;
    else if     (in_tdata == dec_calc_pkg::CH_STAR)  ch_op = dec_calc_pkg::OP_MUL;
    else if     (in_tdata == dec_calc_pkg::CH_SLASH) ch_op = dec_calc_pkg::OP_DIV;
    else                                             ch_op = dec_calc_pkg::OP_NONE;
  end

  // Decimal accumulation: n*10 + digit as (n<<3) + (n<<1) + digit, wrapping.
  logic [W-1:0] acc_src;
  logic [W-1:0] acc_ten;
  assign acc_src = (phase_r == dec_calc_pkg::PH_FIRST) ? a_r : b_r;
  assign acc_ten = (acc_src << 3) + (acc_src << 1) + {{(W-4){1'b0}}, digit};

  // Shared adder/subtractor, one extra bit for the borrow of division steps.
  logic [W:0] alu_x;
  logic [W:0] alu_y;
  logic       alu_sub;
  logic [W:0] alu_sum;
  assign alu_sum = alu_x + (alu_sub ? ~alu_y : alu_y) + {{W{1'b0}}, alu_sub};

  always_comb begin
    alu_x   = {1'b0, a_r};
    alu_y   = {1'b0, b_r};
    alu_sub = 1'b0;
    unique case (state_r)
      S_ADDSUB: alu_sub = (op_r == dec_calc_pkg::OP_SUB);
      S_MUL: begin
        alu_x = {1'b0, acc_r};
        alu_y = {1'b0, a_r};
      end
      S_NEGA: begin
        alu_x   = '0;
        alu_y   = {1'b0, a_r};
        alu_sub = 1'b1;
      end
      S_NEGB: begin
        alu_x   = '0;
        alu_y   = {1'b0, b_r};
        alu_sub = 1'b1;
      end
      S_DIV: begin
        alu_x   = {acc_r, a_r[W-1]};
        alu_y   = {1'b0, b_r};
        alu_sub = 1'b1;
      end
      S_FIX: begin
        alu_x   = '0;
        alu_y   = {1'b0, a_r};
        alu_sub = 1'b1;
      end
      S_IDLE, S_DONE: begin
        alu_x = {1'b0, a_r};
      end
      default: begin
        alu_x = {1'b0, a_r};
      end
    endcase
  end

  logic cnt_last;
  assign cnt_last = (cnt_r == {CW{1'b1}});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      phase_r      <= dec_calc_pkg::PH_FIRST;
      op_r         <= dec_calc_pkg::OP_NONE;
      a_r          <= '0;
      b_r          <= '0;
      cnt_r        <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      // Retire the waiting result once taken; the done state reloads it itself.
      if (out_tvalid_r && out_tready && (state_r != S_DONE)) begin
        out_tvalid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            if (in_tdata == dec_calc_pkg::CH_NUL) begin
              // End of line: pick the evaluation path.
              st_r  <= dec_calc_pkg::ST_OK;
              acc_r <= '0;
              cnt_r <= '0;
              neg_r <= a_r[W-1] ^ b_r[W-1];
              unique case (op_r)
                dec_calc_pkg::OP_ADD, dec_calc_pkg::OP_SUB: state_r <= S_ADDSUB;
                dec_calc_pkg::OP_MUL: state_r <= S_MUL;
                dec_calc_pkg::OP_DIV: begin
                  if (b_r == '0) begin
                    st_r    <= dec_calc_pkg::ST_DIVZ;
                    state_r <= S_DONE;
                  end else begin
                    state_r <= S_NEGA;
                  end
                end
                default: begin
                  st_r    <= dec_calc_pkg::ST_BAD;
                  state_r <= S_DONE;
                end
              endcase
            end else begin
              unique case (phase_r)
                dec_calc_pkg::PH_FIRST: begin
                  if (is_digit) begin
                    a_r <= acc_ten;
                  end else begin
                    op_r    <= ch_op;
                    phase_r <= (ch_op != dec_calc_pkg::OP_NONE) ?
                               dec_calc_pkg::PH_SECOND : dec_calc_pkg::PH_IGNORE;
                  end
                end
                dec_calc_pkg::PH_SECOND: begin
                  if (is_digit) begin
                    b_r <= acc_ten;
                  end else begin
                    phase_r <= dec_calc_pkg::PH_IGNORE;
                  end
                end
                default: begin
                end
              endcase
            end
          end
        end

        S_ADDSUB: begin
          acc_r   <= alu_sum[W-1:0];
          state_r <= S_DONE;
        end

        // Shift-add: one multiplier bit per cycle, low word kept.
        S_MUL: begin
          if (b_r[0]) begin
            acc_r <= alu_sum[W-1:0];
          end
          a_r   <= a_r << 1;
          b_r   <= b_r >> 1;
          cnt_r <= cnt_r + 1'b1;
          if (cnt_last) begin
            state_r <= S_DONE;
          end
        end

        S_NEGA: begin
          if (a_r[W-1]) begin
            a_r <= alu_sum[W-1:0];
          end
          state_r <= S_NEGB;
        end

        S_NEGB: begin
          if (b_r[W-1]) begin
            b_r <= alu_sum[W-1:0];
          end
          state_r <= S_DIV;
        end

        // Restoring division: shift dividend bit into the remainder, keep
        // the difference when it does not borrow.
        S_DIV: begin
          if (!alu_sum[W]) begin
            acc_r <= alu_sum[W-1:0];
          end else begin
            acc_r <= alu_x[W-1:0];
          end
          a_r   <= {a_r[W-2:0], !alu_sum[W]};
          cnt_r <= cnt_r + 1'b1;
          if (cnt_last) begin
            state_r <= S_FIX;
          end
        end

        S_FIX: begin
          acc_r   <= neg_r ? alu_sum[W-1:0] : a_r;
          state_r <= S_DONE;
        end

        // Hold until the output register is free, then clear the line state.
        S_DONE: begin
          if (out_free) begin
            out_tvalid_r <= 1'b1;
            out_value_r  <= acc_r;
            out_status_r <= st_r;
            phase_r      <= dec_calc_pkg::PH_FIRST;
            op_r         <= dec_calc_pkg::OP_NONE;
            a_r          <= '0;
            b_r          <= '0;
            state_r      <= S_IDLE;
          end
        end

        default: state_r <= S_IDLE;
      endcase
    end
  end

  // A result only leaves the sequencer's done state.
  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid_r) |-> $past(state_r == S_DONE))
    else $error("result appeared outside the done state");

  // Error statuses carry a zero value.
  a_status_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid_r |-> (out_status_r == dec_calc_pkg::ST_OK || out_value_r == '0))
    else $error("nonzero value with error status");

  // The unused status code never goes out.
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid_r |-> (out_status_r == dec_calc_pkg::ST_OK ||
                      out_status_r == dec_calc_pkg::ST_BAD ||
                      out_status_r == dec_calc_pkg::ST_DIVZ))
    else $error("undefined status code");

  // Iteration counter is back at zero whenever a new line can start.
  a_cnt_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (cnt_r == '0))
    else $error("iteration counter not cleared in idle");

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for the decimal expression calculator stream block.
`timescale 1ns / 1ps

module testbench;

  // One pending input request; hold marks a pause until all lines are answered.
  typedef struct {
    logic [7:0] ch;
    bit         hold;
  } char_req_t;

  typedef struct packed {
    logic [31:0] value;
    logic [1:0]  status;
  } line_result_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = 8'h00;  // [7:0] ch
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;           // [31:0] value (signed)
  logic [1:0]  out_tuser;           // [1:0] status

  char_req_t    pending_chars[$];
  line_result_t line_results[$];

  // Line parser mirror
  dec_calc_pkg::phase_t parse_phase = dec_calc_pkg::PH_FIRST;
  dec_calc_pkg::op_t    pend_op     = dec_calc_pkg::OP_NONE;
  logic [31:0]          lhs_acc     = '0;
  logic [31:0]          rhs_acc     = '0;

  logic [7:0] op_chars [4] = '{dec_calc_pkg::CH_PLUS, dec_calc_pkg::CH_MINUS,
                               dec_calc_pkg::CH_STAR, dec_calc_pkg::CH_SLASH};

  bit in_taken   = 1'b0;  // request accepted at the last rising edge
  bit drain_wait = 1'b0;
  bit quiet      = 1'b0;  // no idling in the closing stretch
  int fails      = 0;

  decimal_expression_calculator u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #6 clk = ~clk;

  function automatic logic [31:0] times_ten_plus(logic [31:0] acc, logic [7:0] ch);
    return acc * 32'd10 + {24'd0, ch - dec_calc_pkg::CH_ZERO};
  endfunction

  function automatic dec_calc_pkg::op_t op_from_char(logic [7:0] ch);
    case (ch)
      dec_calc_pkg::CH_PLUS:  return dec_calc_pkg::OP_ADD;
      dec_calc_pkg::CH_MINUS: return dec_calc_pkg::OP_SUB;
      dec_calc_pkg::CH_STAR:  return dec_calc_pkg::OP_MUL;
      dec_calc_pkg::CH_SLASH: return dec_calc_pkg::OP_DIV;
      default:                return dec_calc_pkg::OP_NONE;
    endcase
  endfunction

  function automatic bit is_digit_char(logic [7:0] ch);
    return ch >= dec_calc_pkg::CH_ZERO && ch <= dec_calc_pkg::CH_NINE;
  endfunction

  // Signed divide on magnitudes so that min / -1 wraps back to min.
  function automatic logic [31:0] quot_toward_zero(logic [31:0] a, logic [31:0] b);
    logic [31:0] ma;
    logic [31:0] mb;
    logic [31:0] q;
    ma = a[31] ? -a : a;
    mb = b[31] ? -b : b;
    q  = ma / mb;
    return (a[31] != b[31]) ? -q : q;
  endfunction

  // Advance the parser mirror by one accepted character; queue a result on NUL.
  task automatic track_char(input logic [7:0] ch);
    line_result_t res;
    if (ch == dec_calc_pkg::CH_NUL) begin
      res = '{value: 32'd0, status: dec_calc_pkg::ST_OK};
      case (pend_op)
        dec_calc_pkg::OP_ADD: res.value = lhs_acc + rhs_acc;
        dec_calc_pkg::OP_SUB: res.value = lhs_acc - rhs_acc;
        dec_calc_pkg::OP_MUL: res.value = lhs_acc * rhs_acc;
        dec_calc_pkg::OP_DIV: begin
          if (rhs_acc == 32'd0) res.status = dec_calc_pkg::ST_DIVZ;
          else res.value = quot_toward_zero(lhs_acc, rhs_acc);
        end
        default: res.status = dec_calc_pkg::ST_BAD;
      endcase
      line_results.push_back(res);
      parse_phase = dec_calc_pkg::PH_FIRST;
      pend_op     = dec_calc_pkg::OP_NONE;
      lhs_acc     = '0;
      rhs_acc     = '0;
    end else begin
      case (parse_phase)
        dec_calc_pkg::PH_FIRST: begin
          if (is_digit_char(ch)) begin
            lhs_acc = times_ten_plus(lhs_acc, ch);
          end else begin
            pend_op     = op_from_char(ch);
            parse_phase = (pend_op != dec_calc_pkg::OP_NONE) ?
                          dec_calc_pkg::PH_SECOND : dec_calc_pkg::PH_IGNORE;
          end
        end
        dec_calc_pkg::PH_SECOND: begin
          if (is_digit_char(ch)) rhs_acc = times_ten_plus(rhs_acc, ch);
          else parse_phase = dec_calc_pkg::PH_IGNORE;
        end
        default: ;  // ignore the rest of the line
      endcase
    end
  endtask

  // Monitor: record input requests and check each result against the oldest line.
  always @(posedge clk) begin : watch_ports
    line_result_t want;
    in_taken = 1'b0;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        in_taken = 1'b1;
        track_char(in_tdata);
      end
      if (out_tvalid && out_tready) begin
        if (line_results.size() == 0) begin
          $display("%0t: unexpected result value %0d status %0d", $realtime,
                   $signed(out_tdata), out_tuser);
          fails++;
        end else begin
          want = line_results.pop_front();
          if (out_tdata !== want.value) begin
            $display("%0t: value mismatch, expected %0d got %0d", $realtime,
                     $signed(want.value), $signed(out_tdata));
            fails++;
          end
          if (out_tuser !== want.status) begin
            $display("%0t: status mismatch, expected %0d got %0d", $realtime,
                     want.status, out_tuser);
            fails++;
          end
        end
      end
    end
  end

  // Driver: present characters at the falling edge, idling in random bursts.
  always @(negedge clk) begin : drive_chars
    char_req_t nxt;
    int        gap_left;
    int        idle_pct;
    int        seg_cnt;
    if (rst_n) begin
      quiet = (pending_chars.size() < 150);
      // Change the idle density every so often, zero included.
      if (seg_cnt == 0) begin
        seg_cnt  = 64;
        idle_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 40);
      end
      seg_cnt--;
      if (in_tvalid && !in_taken) begin
        in_tvalid <= 1'b1;  // hold the request until it is taken
      end else if (drain_wait) begin
        if (line_results.size() == 0) drain_wait = 1'b0;
        in_tvalid <= 1'b0;
      end else if (gap_left > 0) begin
        gap_left--;
        in_tvalid <= 1'b0;
      end else if (pending_chars.size() == 0) begin
        in_tvalid <= 1'b0;
      end else if (!quiet && $urandom_range(0, 99) < idle_pct) begin
        gap_left = $urandom_range(1, 4) - 1;
        in_tvalid <= 1'b0;
      end else begin
        nxt = pending_chars.pop_front();
        if (nxt.hold) begin
          drain_wait = 1'b1;
          in_tvalid <= 1'b0;
        end else begin
          in_tvalid <= 1'b1;
          in_tdata  <= nxt.ch;
        end
      end
    end
  end

  // Receiver: drop out_tready in random bursts, never in the closing stretch.
  always @(negedge clk) begin : drive_ready
    int stall_left;
    int stall_pct;
    int seg_cnt;
    if (seg_cnt == 0) begin
      seg_cnt   = 80;
      stall_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 40);
    end
    seg_cnt--;
    if (quiet) begin
      out_tready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else if ($urandom_range(0, 99) < stall_pct) begin
      stall_left = $urandom_range(1, 4) - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  task automatic push_char(input logic [7:0] ch);
    pending_chars.push_back('{ch: ch, hold: 1'b0});
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) push_char(s[i]);
  endtask

  task automatic push_digits(input int n);
    repeat (n) push_char(dec_calc_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
  endtask

  task automatic push_junk(input int n);
    repeat (n) push_char(8'($urandom_range(1, 255)));
  endtask

  function automatic int pick_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 14) : $urandom_range(0, 4);
  endfunction

  initial begin : run_main
    int  kind;
    bit  mid_hold;
    // Directed lines: empty line, each operator, divide by zero, missing
    // numbers, junk in the first number, operator not right after the number.
    push_char(dec_calc_pkg::CH_NUL);
    push_text("7+5");       push_char(dec_calc_pkg::CH_NUL);
    push_text("3-9");       push_char(dec_calc_pkg::CH_NUL);
    push_text("6*7");       push_char(dec_calc_pkg::CH_NUL);
    push_text("8/0");       push_char(dec_calc_pkg::CH_NUL);
    push_text("-2");        push_char(dec_calc_pkg::CH_NUL);
    push_text("5/");        push_char(dec_calc_pkg::CH_NUL);
    push_char(8'hFF);       push_text("1+2"); push_char(dec_calc_pkg::CH_NUL);
    push_text("1 +2");      push_char(dec_calc_pkg::CH_NUL);
    pending_chars.push_back('{ch: dec_calc_pkg::CH_NUL, hold: 1'b1});

    mid_hold = 1'b0;
    while (pending_chars.size() < 1780) begin
      kind = $urandom_range(0, 99);
      if (kind < 70) begin
        // Well-formed line with random content, sometimes with a tail.
        push_digits(pick_len());
        push_char(op_chars[$urandom_range(0, 3)]);
        push_digits(pick_len());
        if ($urandom_range(0, 3) == 0) push_junk($urandom_range(1, 4));
      end else if (kind < 74) begin
        push_text("2147483648/4294967295");  // most negative over -1
      end else if (kind < 80) begin
        push_digits(pick_len());
        case ($urandom_range(0, 2))
          0:       push_text("/0");
          1:       push_text("/000");
          default: push_text("/4294967296");  // divisor wraps to zero
        endcase
      end else if (kind < 90) begin
        push_junk($urandom_range(0, 8));
      end else begin
        push_digits(pick_len());
        push_junk($urandom_range(1, 3));
        push_char(op_chars[$urandom_range(0, 3)]);
        push_digits(pick_len());
      end
      push_char(dec_calc_pkg::CH_NUL);
      if (!mid_hold && pending_chars.size() > 900) begin
        mid_hold = 1'b1;
        pending_chars.push_back('{ch: dec_calc_pkg::CH_NUL, hold: 1'b1});
      end
    end

    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    // Wait for every request to go out and every line to be answered.
    do @(negedge clk);
    while (pending_chars.size() != 0 || in_tvalid || drain_wait || line_results.size() != 0);
    repeat (64) @(negedge clk);

    if (line_results.size() != 0) begin
      $display("%0t: %0d results never arrived", $realtime, line_results.size());
      fails++;
    end
    if (fails == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
